FILE: rtl/pfdr_pkg.sv
// ----------------------------------------------------------------------------
// Pose frame deframer package
// Shared constants, output byte source table and address helper.
// ----------------------------------------------------------------------------
package pfdr_pkg;

   localparam int unsigned IN_FRAME_LEN  = 36;
   localparam int unsigned OUT_FRAME_LEN = 26;
   localparam int unsigned IDX_W         = 6;
   localparam int unsigned OUT_IDX_W     = 5;

   localparam logic [7:0] HDR_FIRST  = 8'h50;
   localparam logic [7:0] HDR_SECOND = 8'h54;
   localparam logic [7:0] INFO_LH1   = 8'h40;
   localparam logic [7:0] INFO_LH2   = 8'h80;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(IN_FRAME_LEN - 1);

   localparam logic CSR_NODE_ID  = 1'b0;
   localparam logic CSR_INFO_TOP = 1'b1;

   typedef enum logic [2:0] {
      SRC_HDR,
      SRC_ID,
      SRC_MEM,
      SRC_QLO,
      SRC_QHI,
      SRC_INFO,
      SRC_SUM
   } src_kind_type;

   typedef struct packed {
      src_kind_type     kind;
      logic [IDX_W-1:0] idx;
   } src_type;

   // Where each output byte comes from; idx is the frame offset in the buffer
   function automatic src_type out_src(input logic [OUT_IDX_W-1:0] k);
      src_type s;
      s.kind = SRC_MEM;
      s.idx  = '0;
      unique case (k)
         5'd0:  s.kind = SRC_HDR;
         5'd1:  s.kind = SRC_ID;
         5'd2:  s.idx = 6'd3;
         5'd3:  s.idx = 6'd4;
         5'd4:  s.idx = 6'd7;
         5'd5:  s.idx = 6'd8;
         5'd6:  s.idx = 6'd11;
         5'd7:  s.idx = 6'd12;
         5'd8, 5'd14:  begin s.kind = SRC_QLO; s.idx = 6'd19; end
         5'd9, 5'd15:  begin s.kind = SRC_QHI; s.idx = 6'd20; end
         5'd10, 5'd16: begin s.kind = SRC_QLO; s.idx = 6'd23; end
         5'd11, 5'd17: begin s.kind = SRC_QHI; s.idx = 6'd24; end
         5'd12, 5'd18: begin s.kind = SRC_QLO; s.idx = 6'd27; end
         5'd13, 5'd19: begin s.kind = SRC_QHI; s.idx = 6'd28; end
         5'd20: s.idx = 6'd31;
         5'd21: s.idx = 6'd32;
         5'd22: s.idx = 6'd33;
         5'd23: s.idx = 6'd34;
         5'd24: s.kind = SRC_INFO;
         default: s.kind = SRC_SUM;
      endcase
      return s;
   endfunction

   // Circular buffer offset: both operands below the frame length
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IDX_W+1)'(IN_FRAME_LEN))
         s = s - (IDX_W+1)'(IN_FRAME_LEN);
      return s[IDX_W-1:0];
   endfunction

endpackage

FILE: rtl/pose_frame_deframer_repacker.sv
// ----------------------------------------------------------------------------
// Pose frame deframer and repacker
// Takes 36-byte pose frames a byte at a time, emits 26-byte repacked frames.
// ----------------------------------------------------------------------------
// Flow: a byte that does not complete the buffer is written to the RAM and
// the block stays ready. The completing byte starts a scan over the RAM (one
// read port, one byte a cycle), then a decide step; each output byte passes
// ST_EMIT_RD, ST_EMIT_LD and ST_EMIT_WAIT, which waits for rsp_tready.
// Reset (synchronous, active high) empties the buffer, sets node_id 0 and
// info_top_bit 1; the RAM is not cleared.
module pose_frame_deframer_repacker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [11:8] key_state, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] tx_byte
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [3:0]  csr_wdata
);

   localparam int unsigned IW = pfdr_pkg::IDX_W;
   localparam int unsigned OW = pfdr_pkg::OUT_IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
   } state_type;

   state_type       state_ff, state_in;
   logic [IW-1:0]   head_ff, head_in, fill_ff, fill_in;
   logic [IW:0]     scan_cnt_ff, scan_cnt_in;
   logic            rd_vld_ff, rd_vld_in;
   logic [IW-1:0]   rd_idx_ff, rd_idx_in;
   logic [7:0]      prev_ff, prev_in, last_ff, last_in, info_ff, info_in;
   logic [7:0]      sum_ff, sum_in;
   logic            f0_ff, f0_in, f2_ff, f2_in;
   logic [IW-1:0]   h0_ff, h0_in, h2_ff, h2_in;
   logic [5:0]      pos_hi_ff, pos_hi_in;
   logic            neg_ff, neg_in, carry_ff, carry_in;
   logic [3:0]      key_ff, key_in, node_id_ff;
   logic            info_top_ff;
   logic [OW-1:0]   k_ff, k_in;
   logic            out_vld_ff, out_vld_in, out_last_ff, out_last_in;
   logic [7:0]      out_data_ff, out_data_in;

   logic            wr_en;
   logic [IW-1:0]   wr_addr, rd_addr, rd_off, pos, drop_n;
   logic [7:0]      rdata, byte_v;
   logic            pair;
   pfdr_pkg::src_type src;

   pfdr_ram #(
      .WIDTH(8),
      .DEPTH(pfdr_pkg::IN_FRAME_LEN)
   ) u_buf (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_tdata[7:0]),
      .rd_addr(rd_addr),
      .rd_data(rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign wr_en      = req_tvalid && req_tready;
   assign wr_addr    = pfdr_pkg::wrap_add(head_ff, fill_ff);
   assign src        = pfdr_pkg::out_src(k_ff);
   assign rd_off     = (state_ff == ST_SCAN) ? scan_cnt_ff[IW-1:0] : src.idx;
   assign rd_addr    = pfdr_pkg::wrap_add(head_ff, rd_off);
   assign pos        = rd_idx_ff - IW'(1);
   assign pair       = (rd_idx_ff != '0) && (prev_ff == pfdr_pkg::HDR_FIRST)
                       && (rdata == pfdr_pkg::HDR_SECOND);

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      drop_n = f0_ff ? h0_ff : pfdr_pkg::LAST_IDX;
      if (drop_n == '0)
         drop_n = f2_ff ? h2_ff : pfdr_pkg::LAST_IDX;
   end

   always_comb begin
      byte_v   = rdata;
      carry_in = carry_ff;
      case (src.kind)
         pfdr_pkg::SRC_HDR:  byte_v = pfdr_pkg::HDR_FIRST;
         pfdr_pkg::SRC_ID:   byte_v = {key_ff, node_id_ff};
         pfdr_pkg::SRC_QLO: begin
            carry_in = (rdata == 8'h00);
            if (neg_ff)
               byte_v = ~rdata + 8'd1;
         end
         pfdr_pkg::SRC_QHI: begin
            if (neg_ff)
               byte_v = ~rdata + {7'd0, carry_ff};
         end
         pfdr_pkg::SRC_INFO: byte_v = {info_top_ff, (info_ff == pfdr_pkg::INFO_LH2),
                                       pos_hi_ff};
         pfdr_pkg::SRC_SUM:  byte_v = sum_ff;
         default:            byte_v = rdata;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      scan_cnt_in = scan_cnt_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      prev_in     = prev_ff;
      last_in     = last_ff;
      info_in     = info_ff;
      sum_in      = sum_ff;
      f0_in       = f0_ff;
      f2_in       = f2_ff;
      h0_in       = h0_ff;
      h2_in       = h2_ff;
      pos_hi_in   = pos_hi_ff;
      neg_in      = neg_ff;
      key_in      = key_ff;
      k_in        = k_ff;
      out_vld_in  = out_vld_ff;
      out_last_in = out_last_ff;
      out_data_in = out_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (wr_en) begin
               key_in = req_tdata[11:8];
               if (fill_ff == pfdr_pkg::LAST_IDX) begin
                  fill_in     = IW'(pfdr_pkg::IN_FRAME_LEN);
                  scan_cnt_in = '0;
                  sum_in      = '0;
                  f0_in       = 1'b0;
                  f2_in       = 1'b0;
                  state_in    = ST_SCAN;
               end else begin
                  fill_in = fill_ff + IW'(1);
               end
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff != (IW+1)'(pfdr_pkg::IN_FRAME_LEN)) begin
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_cnt_ff[IW-1:0];
               scan_cnt_in = scan_cnt_ff + (IW+1)'(1);
            end
            if (rd_vld_ff) begin
               prev_in = rdata;
               if (pair && !f0_ff) begin
                  f0_in = 1'b1;
                  h0_in = pos;
               end
               if (pair && !f2_ff && (pos >= IW'(2))) begin
                  f2_in = 1'b1;
                  h2_in = pos;
               end
               if (rd_idx_ff == pfdr_pkg::LAST_IDX) begin
                  last_in  = rdata;
                  state_in = ST_DECIDE;
               end else begin
                  sum_in = sum_ff + rdata;
               end
               case (rd_idx_ff)
                  6'd2:  info_in        = rdata;
                  6'd5:  pos_hi_in[1:0] = rdata[1:0];
                  6'd9:  pos_hi_in[3:2] = rdata[1:0];
                  6'd13: pos_hi_in[5:4] = rdata[1:0];
                  6'd18: neg_in         = rdata[7];
                  default: ;
               endcase
            end
         end
         ST_DECIDE: begin
            if (!(f0_ff && h0_ff == '0) || (sum_ff != last_ff)) begin
               // realign: drop everything before the next header
               head_in  = pfdr_pkg::wrap_add(head_ff, drop_n);
               fill_in  = IW'(pfdr_pkg::IN_FRAME_LEN) - drop_n;
               state_in = ST_IDLE;
            end else begin
               fill_in = '0;
               if ((info_ff == pfdr_pkg::INFO_LH1) || (info_ff == pfdr_pkg::INFO_LH2)) begin
                  k_in     = '0;
                  sum_in   = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            out_data_in = byte_v;
            out_vld_in  = 1'b1;
            out_last_in = (k_ff == OW'(pfdr_pkg::OUT_FRAME_LEN - 1));
            sum_in      = sum_ff + byte_v;
            state_in    = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_tready) begin
               out_vld_in = 1'b0;
               if (out_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + OW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         fill_ff     <= '0;
         out_vld_ff  <= 1'b0;
         rd_vld_ff   <= 1'b0;
         node_id_ff  <= '0;
         info_top_ff <= 1'b1;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         fill_ff    <= fill_in;
         out_vld_ff <= out_vld_in;
         rd_vld_ff  <= rd_vld_in;
         if (csr_we) begin
            unique case (csr_addr)
               pfdr_pkg::CSR_NODE_ID:  node_id_ff  <= csr_wdata;
               pfdr_pkg::CSR_INFO_TOP: info_top_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      scan_cnt_ff <= scan_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      prev_ff     <= prev_in;
      last_ff     <= last_in;
      info_ff     <= info_in;
      sum_ff      <= sum_in;
      f0_ff       <= f0_in;
      f2_ff       <= f2_in;
      h0_ff       <= h0_in;
      h2_ff       <= h2_in;
      pos_hi_ff   <= pos_hi_in;
      neg_ff      <= neg_in;
      carry_ff    <= (state_ff == ST_EMIT_LD) ? carry_in : carry_ff;
      key_ff      <= key_in;
      k_ff        <= k_in;
      out_last_ff <= out_last_in;
      out_data_ff <= out_data_in;
   end

endmodule

FILE: rtl/pfdr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfdr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = pfdr_pkg::IN_FRAME_LEN
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/pfdr_checker.sv
// ----------------------------------------------------------------------------
// Pose frame deframer port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module pfdr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // hold a stalled output transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled output transfer changed");

   // no input taken while a frame is being emitted
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready during output");

   // the gap after the last byte of a frame
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("no return to idle after frame end");

   // output byte after a transfer needs a fresh load
   a_byte_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("back-to-back output bytes");

endmodule

bind pose_frame_deframer_repacker pfdr_checker u_pfdr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);

FILE: bench/tb_pose_frame_deframer_repacker.sv
// ----------------------------------------------------------------------------
// Pose frame deframer and repacker testbench
// Streams received bytes into the block (well-formed pose frames with random
// content, broken frames and noise), predicts the repacked output bytes and
// checks every output transfer against them across three register settings.
// ----------------------------------------------------------------------------
module tb_pose_frame_deframer_repacker;
   timeunit 1ns;
   timeprecision 1ps;

   import pfdr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned DRAIN_WAIT  = 200;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } tx_item_type;

   class repack_scoreboard;
      logic [7:0]  rx_buf [IN_FRAME_LEN];
      int unsigned fill;
      logic [3:0]  node_id;
      logic        info_top;
      tx_item_type tx_expected [$];
      int unsigned mismatches;

      function new();
         foreach (rx_buf[i]) rx_buf[i] = '0;
         fill       = 0;
         node_id    = '0;
         info_top   = 1'b1;
         mismatches = 0;
      endfunction

      function void set_reg(logic addr, logic [3:0] value);
         if (addr == CSR_NODE_ID) node_id = value;
         else info_top = value[0];
      endfunction

      function int unsigned find_header(int unsigned from);
         for (int unsigned i = from; i + 1 < IN_FRAME_LEN; i++)
            if (rx_buf[i] == HDR_FIRST && rx_buf[i+1] == HDR_SECOND) return i;
         return IN_FRAME_LEN - 1;
      endfunction

      function void drop_front(int unsigned n);
         if (n > fill) n = fill;
         for (int unsigned i = 0; i + n < fill; i++) rx_buf[i] = rx_buf[i+n];
         fill -= n;
      endfunction

      function logic [31:0] word_at(int unsigned off);
         return {rx_buf[off+3], rx_buf[off+2], rx_buf[off+1], rx_buf[off]};
      endfunction

      function void note_input(logic [7:0] rx, logic [3:0] key);
         logic [7:0]  sum;
         logic [31:0] px, py, pz, qw, ts;
         logic [31:0] q [3];
         logic        lh;
         logic [7:0]  ob [OUT_FRAME_LEN];
         tx_item_type it;
         if (fill >= IN_FRAME_LEN) fill = 0;
         rx_buf[fill] = rx;
         fill++;
         if (fill < IN_FRAME_LEN) return;
         drop_front(find_header(0));
         if (fill < IN_FRAME_LEN) return;
         sum = '0;
         for (int i = 0; i < IN_FRAME_LEN - 1; i++) sum += rx_buf[i];
         if (rx_buf[IN_FRAME_LEN-1] != sum) begin
            drop_front(find_header(2));
            return;
         end
         fill = 0;
         if (rx_buf[2] == INFO_LH1) lh = 1'b0;
         else if (rx_buf[2] == INFO_LH2) lh = 1'b1;
         else return;
         px = word_at(3);  py = word_at(7);  pz = word_at(11); qw = word_at(15);
         q[0] = word_at(19); q[1] = word_at(23); q[2] = word_at(27);
         ts = word_at(31);
         // fold the quaternion sign by w
         if (qw[31]) for (int i = 0; i < 3; i++) q[i] = 32'd0 - q[i];
         ob[0] = HDR_FIRST;
         ob[1] = {key, node_id};
         ob[2] = px[7:0]; ob[3] = px[15:8];
         ob[4] = py[7:0]; ob[5] = py[15:8];
         ob[6] = pz[7:0]; ob[7] = pz[15:8];
         for (int i = 0; i < 6; i++) begin
            ob[8+2*i] = q[i%3][7:0];
            ob[9+2*i] = q[i%3][15:8];
         end
         ob[20] = ts[7:0]; ob[21] = ts[15:8]; ob[22] = ts[23:16]; ob[23] = ts[31:24];
         ob[24] = {info_top, lh, pz[17:16], py[17:16], px[17:16]};
         sum = '0;
         for (int i = 0; i < OUT_FRAME_LEN - 1; i++) sum += ob[i];
         ob[OUT_FRAME_LEN-1] = sum;
         for (int i = 0; i < OUT_FRAME_LEN; i++) begin
            it.tx_byte = ob[i];
            it.tx_last = (i == OUT_FRAME_LEN - 1);
            tx_expected.push_back(it);
         end
      endfunction

      function void check_result(logic [7:0] tx, logic last);
         tx_item_type want;
         if (tx_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected output byte %02h last %0b", tx, last);
            return;
         end
         want = tx_expected.pop_front();
         if (want.tx_byte !== tx || want.tx_last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("output mismatch: expected %02h/%0b got %02h/%0b",
                        want.tx_byte, want.tx_last, tx, last);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_addr = CSR_NODE_ID;
   logic [3:0]  csr_wdata = '0;

   repack_scoreboard sb = new();
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned bytes_sent = 0;
   int unsigned cycles = 0;
   int unsigned tx_seen = 0;
   int unsigned hold_left = 0;
   bit          held_once = 1'b0;
   logic [7:0]  frame_buf [IN_FRAME_LEN];

   pose_frame_deframer_repacker u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: check transfers, stall at random, one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tlast);
         tx_seen <= tx_seen + 1;
      end
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!held_once && tx_seen == 30) begin
         held_once  <= 1'b1;
         hold_left  <= 600;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      logic [3:0] key;
      key = 4'($urandom);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, key, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(b, key);
      bytes_sent++;
   endtask

   // fill frame_buf with a frame; bad_sum flips the checksum
   task automatic build_frame(input logic [7:0] info, input logic [31:0] w [8],
                              input bit bad_sum);
      logic [7:0] sum;
      frame_buf[0] = HDR_FIRST;
      frame_buf[1] = HDR_SECOND;
      frame_buf[2] = info;
      for (int i = 0; i < 8; i++)
         for (int k = 0; k < 4; k++) frame_buf[3+4*i+k] = w[i][8*k +: 8];
      sum = '0;
      for (int i = 0; i < IN_FRAME_LEN - 1; i++) sum += frame_buf[i];
      frame_buf[IN_FRAME_LEN-1] = bad_sum ? sum ^ 8'(1 << $urandom_range(0, 7)) : sum;
   endtask

   task automatic send_frame(input logic [7:0] info, input logic [31:0] w [8],
                             input bit bad_sum);
      build_frame(info, w, bad_sum);
      for (int i = 0; i < IN_FRAME_LEN; i++) send_byte(frame_buf[i]);
   endtask

   task automatic csr_write(input logic addr, input logic [3:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_reg(addr, value);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.tx_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic random_traffic(input int unsigned count);
      logic [31:0] w [8];
      int unsigned stop_at;
      int unsigned pick;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         foreach (w[i]) w[i] = $urandom;
         if (pick == 0) begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
         end else if (pick == 1) begin
            send_frame($urandom_range(0, 1) ? INFO_LH1 : INFO_LH2, w, 1'b1);
         end else if (pick == 2) begin
            send_frame(8'($urandom), w, 1'b0);
         end else begin
            send_frame($urandom_range(0, 1) ? INFO_LH1 : INFO_LH2, w, 1'b0);
         end
      end
   endtask

   task automatic directed_frames();
      logic [31:0] w [8];
      foreach (w[i]) w[i] = '0;
      send_frame(INFO_LH1, w, 1'b0);
      foreach (w[i]) w[i] = 32'hffff_ffff;
      send_frame(INFO_LH2, w, 1'b0);
      // most negative components under a negative w
      foreach (w[i]) w[i] = 32'h8000_0000;
      w[0] = 32'h0003_0000; w[1] = 32'h0001_ffff; w[2] = 32'h0002_0001;
      send_frame(INFO_LH1, w, 1'b0);
      send_frame(INFO_LH2, w, 1'b1);
      send_frame(8'h00, w, 1'b0);
      // junk ahead of a header
      send_byte(8'h00); send_byte(HDR_FIRST); send_byte(8'hff);
      foreach (w[i]) w[i] = $urandom;
      send_frame(INFO_LH2, w, 1'b0);
      // a full buffer with no header
      for (int i = 0; i < IN_FRAME_LEN; i++) send_byte(HDR_FIRST);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      csr_write(CSR_NODE_ID, 4'h0);
      csr_write(CSR_INFO_TOP, 4'h1);

      send_idle_pct = 8;
      recv_idle_pct = 72;
      directed_frames();
      random_traffic(60);
      settle();

      csr_write(CSR_NODE_ID, 4'hf);
      csr_write(CSR_INFO_TOP, 4'h0);
      send_idle_pct = 72;
      recv_idle_pct = 8;
      random_traffic(60);
      settle();

      csr_write(CSR_NODE_ID, 4'($urandom_range(1, 14)));
      csr_write(CSR_INFO_TOP, 4'h1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_traffic(60);
      settle();

      if (sb.mismatches == 0 && sb.tx_expected.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
